// ----- rtl/double_ended_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Clocked assertion wrappers used by the queue RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside of reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define DQ_ASSERT(lbl, prop, msg)
`define DQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, port widths and parameter defaults.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_REVERSE    = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of words held in a ring memory with a direction flag.
// ----------------------------------------------------------------------------
// Each accepted command runs through the states ST_READ and ST_RESP. In the
// cycle of the accept the pointers, count and direction flag are updated and a
// pushed word is written to the ring memory, while the word to be popped is
// read. In ST_READ both physical ends of the ring are read through the
// memory's two read ports. The result then appears on the result ports for
// exactly one cycle with done_o high, in ST_RESP, and a new command may be
// accepted in that same cycle. busy is high only during the end-read cycle.
// Results cannot be held off by the receiver. Reversal moves no data; it
// flips which physical end counts as the front.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [dq_pkg::FUNC_W-1:0]   func_i,
  input  logic [dq_pkg::WORD_W-1:0]   data_in_i,
  output logic                        done_o,
  output logic [dq_pkg::STATUS_W-1:0] status_o,
  output logic [dq_pkg::WORD_W-1:0]   data_out_o,
  output logic [dq_pkg::COUNT_W-1:0]  count_o,
  output logic [dq_pkg::WORD_W-1:0]   front_value_o,
  output logic [dq_pkg::WORD_W-1:0]   back_value_o
);

  import dq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rev_q, rev_d;
  status_e               status_q, status_d;
  logic                  pop_q, pop_d;
  logic [WORD_W-1:0]     data_out_q;

  logic                  accept;
  logic                  toward_low;
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         pop_addr;
  logic [AW-1:0]         rd_a_addr, rd_b_addr;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [DATA_WIDTH-1:0] word;

  logic [AW-1:0]         head_inc, head_dec, tail_pos, high_pos;
  logic [SW-1:0]         sum_tail, sum_high;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  assign accept = start && !busy;
  assign busy   = (state_q == ST_READ);
  assign word   = DATA_WIDTH'(data_in_i);

  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;

  assign sum_tail = SW'(head_q) + SW'(count_q);
  assign tail_pos = (sum_tail >= SW'(DEPTH)) ? AW'(sum_tail - SW'(DEPTH)) : AW'(sum_tail);
  assign sum_high = sum_tail - 1'b1;
  assign high_pos = (count_q == '0)           ? head_q :
                    (sum_high >= SW'(DEPTH))  ? AW'(sum_high - SW'(DEPTH)) :
                                                AW'(sum_high);

  assign toward_low = (func_i inside {FUNC_PUSH_FRONT, FUNC_POP_FRONT}) ? !rev_q : rev_q;

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    rev_d    = rev_q;
    status_d = STATUS_OK;
    pop_d    = 1'b0;
    we       = 1'b0;
    wr_addr  = tail_pos;
    pop_addr = head_q;
    case (func_i)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (count_q == CW'(DEPTH)) begin
          status_d = STATUS_FULL;
        end else begin
          we      = accept;
          count_d = count_q + 1'b1;
          if (toward_low) begin
            head_d  = head_dec;
            wr_addr = head_dec;
          end
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          pop_d   = 1'b1;
          count_d = count_q - 1'b1;
          if (toward_low) begin
            head_d = head_inc;
          end else begin
            pop_addr = high_pos;
          end
        end
      end
      FUNC_REVERSE: begin
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
        end else begin
          rev_d = !rev_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = ST_READ;
    end else if (state_q == ST_READ) begin
      state_d = ST_RESP;
    end else if (state_q == ST_RESP) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      rev_q    <= 1'b0;
      status_q <= STATUS_OK;
      pop_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        head_q   <= head_d;
        count_q  <= count_d;
        rev_q    <= rev_d;
        status_q <= status_d;
        pop_q    <= pop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      data_out_q <= pop_q ? WORD_W'(rd_a_q) : '0;
    end
  end

  // The accept cycle reads the word to be popped; the next cycle reads both ends.
  assign rd_a_addr = accept ? pop_addr : head_q;
  assign rd_b_addr = high_pos;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= word;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  assign done_o        = (state_q == ST_RESP);
  assign status_o      = status_q;
  assign data_out_o    = data_out_q;
  assign count_o       = COUNT_W'(count_q);
  assign front_value_o = (count_q == '0) ? '0 : WORD_W'(rev_q ? rd_b_q : rd_a_q);
  assign back_value_o  = (count_q == '0) ? '0 : WORD_W'(rev_q ? rd_a_q : rd_b_q);

  `DQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "count exceeds depth")
  `DQ_ASSERT(a_accept_done, accept |-> ##2 done_o, "result not delivered two cycles after accept")
  `DQ_ASSERT(a_full_status, (done_o && status_q == STATUS_FULL) |-> (count_q == CW'(DEPTH)), "full reported with free space")
  `DQ_ASSERT(a_single_word, (done_o && count_q == CW'(1)) |-> (front_value_o == back_value_o), "ends differ with one word held")

endmodule
